// ----- src/sukt_pkg.sv -----
// sukt_pkg: shared constants, codes and the control/status structs of the
// sorted unique-key table. Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sukt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 31;
	localparam int WORD_W   = 64;
	localparam int ACT_W    = 2;
	localparam int STATUS_W = 4;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_UPDATE = 2'd2,
		ACT_DUMP   = 2'd3
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INS_HEAD  = 4'd0,
		ST_INS_TAIL  = 4'd1,
		ST_INS_MID   = 4'd2,
		ST_DUPLICATE = 4'd3,
		ST_FULL      = 4'd4,
		ST_DEL_HEAD  = 4'd5,
		ST_DEL_TAIL  = 4'd6,
		ST_DEL_MID   = 4'd7,
		ST_NOT_FOUND = 4'd8,
		ST_EMPTY     = 4'd9,
		ST_UPDATED   = 4'd10,
		ST_ENTRY     = 4'd11
	} status_t;

	typedef struct packed {
		logic load;
		logic compare;
		logic commit;
		logic dump_emit;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic count_zero;
		logic dump_last;
	} dp_stat_t;

endpackage

// ----- src/sukt_datapath.sv -----
// sukt_datapath: request capture, key table, parallel key compare, shift
// insert/delete, dump read and result register. Depends on sukt_pkg.
`timescale 1ns / 1ps

module sukt_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sukt_pkg::dp_cmd_t               cmd,
	output sukt_pkg::dp_stat_t              stat,
	input  logic [sukt_pkg::ACT_W-1:0]      action,
	input  logic [sukt_pkg::KEY_W-1:0]      key,
	input  logic [sukt_pkg::WORD_W-1:0]     name_word,
	input  logic [sukt_pkg::WORD_W-1:0]     class_word,
	input  logic                            rsp_stall,
	output logic                            rsp_valid,
	output logic [sukt_pkg::STATUS_W-1:0]   status,
	output logic [sukt_pkg::KEY_W-1:0]      out_key,
	output logic [sukt_pkg::WORD_W-1:0]     out_name,
	output logic [sukt_pkg::WORD_W-1:0]     out_class,
	output logic                            last
);
	import sukt_pkg::*;

	action_t             act_q;
	logic [KEY_W-1:0]    key_q;
	logic [WORD_W-1:0]   name_q;
	logic [WORD_W-1:0]   class_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    count_q;

	logic [KEY_W-1:0]    keys_q    [CAPACITY];
	logic [WORD_W-1:0]   names_q   [CAPACITY];
	logic [WORD_W-1:0]   classes_q [CAPACITY];

	logic [KEY_W-1:0]    dn_key    [CAPACITY];
	logic [WORD_W-1:0]   dn_name   [CAPACITY];
	logic [WORD_W-1:0]   dn_class  [CAPACITY];
	logic [KEY_W-1:0]    up_key    [CAPACITY];
	logic [WORD_W-1:0]   up_name   [CAPACITY];
	logic [WORD_W-1:0]   up_class  [CAPACITY];

	logic [CAPACITY-1:0] lt_d, eq_d, lt_q, eq_q;
	logic [CAPACITY+1:0] lt_ext;
	logic [CNT_W-1:0]    pos;
	logic                hit, full, empty;
	logic                ins_ok, del_ok, upd_ok;
	status_t             status_d;

	logic                rsp_valid_q;
	status_t             status_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [WORD_W-1:0]   out_name_q;
	logic [WORD_W-1:0]   out_class_q;
	logic                last_q;
	logic                emit;

	// capture request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q   <= action_t'(action);
			key_q   <= key;
			name_q  <= name_word;
			class_q <= class_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.dump_emit) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// compare every live entry against the requested key
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt_d[i] = (CNT_W'(i) < count_q) && (keys_q[i] < key_q);
			eq_d[i] = (CNT_W'(i) < count_q) && (keys_q[i] == key_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= '0;
			eq_q <= '0;
		end else if (cmd.compare) begin
			lt_q <= lt_d;
			eq_q <= eq_d;
		end
	end

	// lt_q is a run of ones from the bottom: encode where it ends
	assign lt_ext = {1'b0, lt_q, 1'b1};

	always_comb begin
		pos = '0;
		for (int i = 0; i <= CAPACITY; i++) begin
			if (lt_ext[i] && !lt_ext[i+1]) begin
				pos = pos | CNT_W'(i);
			end
		end
	end

	assign hit    = |eq_q;
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign ins_ok = (act_q == ACT_INSERT) && !hit && !full;
	assign del_ok = (act_q == ACT_DELETE) && hit;
	assign upd_ok = (act_q == ACT_UPDATE) && hit;

	always_comb begin
		unique case (act_q)
			ACT_INSERT: begin
				priority if (hit) begin
					status_d = ST_DUPLICATE;
				end else if (full) begin
					status_d = ST_FULL;
				end else if (pos == '0) begin
					status_d = ST_INS_HEAD;
				end else if (pos == count_q) begin
					status_d = ST_INS_TAIL;
				end else begin
					status_d = ST_INS_MID;
				end
			end
			ACT_DELETE: begin
				priority if (empty) begin
					status_d = ST_EMPTY;
				end else if (!hit) begin
					status_d = ST_NOT_FOUND;
				end else if (pos == '0) begin
					status_d = ST_DEL_HEAD;
				end else if (pos + CNT_W'(1) == count_q) begin
					status_d = ST_DEL_TAIL;
				end else begin
					status_d = ST_DEL_MID;
				end
			end
			ACT_UPDATE: begin
				status_d = hit ? ST_UPDATED : ST_NOT_FOUND;
			end
			ACT_DUMP: begin
				status_d = ST_EMPTY;
			end
			default: begin
				status_d = ST_NOT_FOUND;
			end
		endcase
	end

	// table entries: each one holds, loads the captured request, or loads from its lower or its upper neighbor
	for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
		localparam logic [CNT_W-1:0] GI = CNT_W'(g);

		if (g == 0) begin : g_dn_edge
			assign dn_key[g]   = keys_q[g];
			assign dn_name[g]  = names_q[g];
			assign dn_class[g] = classes_q[g];
		end else begin : g_dn
			assign dn_key[g]   = keys_q[g-1];
			assign dn_name[g]  = names_q[g-1];
			assign dn_class[g] = classes_q[g-1];
		end

		if (g == CAPACITY - 1) begin : g_up_edge
			assign up_key[g]   = keys_q[g];
			assign up_name[g]  = names_q[g];
			assign up_class[g] = classes_q[g];
		end else begin : g_up
			assign up_key[g]   = keys_q[g+1];
			assign up_name[g]  = names_q[g+1];
			assign up_class[g] = classes_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.commit) begin
				if (ins_ok && GI == pos) begin
					keys_q[g]    <= key_q;
					names_q[g]   <= name_q;
					classes_q[g] <= class_q;
				end else if (ins_ok && GI > pos) begin
					keys_q[g]    <= dn_key[g];
					names_q[g]   <= dn_name[g];
					classes_q[g] <= dn_class[g];
				end else if (del_ok && GI >= pos) begin
					keys_q[g]    <= up_key[g];
					names_q[g]   <= up_name[g];
					classes_q[g] <= up_class[g];
				end else if (upd_ok && GI == pos) begin
					names_q[g]   <= name_q;
					classes_q[g] <= class_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit && ins_ok) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.commit && del_ok) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// result register
	assign emit = cmd.commit || cmd.dump_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q    <= status_d;
			out_key_q   <= key_q;
			out_name_q  <= '0;
			out_class_q <= '0;
			last_q      <= 1'b1;
		end else if (cmd.dump_emit) begin
			status_q    <= ST_ENTRY;
			out_key_q   <= keys_q[idx_q];
			out_name_q  <= names_q[idx_q];
			out_class_q <= classes_q[idx_q];
			last_q      <= stat.dump_last;
		end
	end

	assign stat.out_free   = !rsp_valid_q || !rsp_stall;
	assign stat.count_zero = empty;
	assign stat.dump_last  = (CNT_W'(idx_q) == count_q - CNT_W'(1));

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_name  = out_name_q;
	assign out_class = out_class_q;
	assign last      = last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(eq_q))
		else $error("key matches more than one entry");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && ins_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the table");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> stat.out_free)
		else $error("result issued over a pending result");
`endif

endmodule

// ----- src/sukt_ctrl.sv -----
// sukt_ctrl: command sequencer of the sorted unique-key table.
// Depends on sukt_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps

module sukt_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [sukt_pkg::ACT_W-1:0]  action,
	input  sukt_pkg::dp_stat_t          stat,
	output sukt_pkg::dp_cmd_t           cmd
);
	import sukt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_EXEC,
		S_DUMP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (action_t'(action) == ACT_DUMP) begin
							state_q <= stat.count_zero ? S_EXEC : S_DUMP;
						end else begin
							state_q <= S_CMP;
						end
					end
				end
				S_CMP: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DUMP: begin
					if (stat.out_free && stat.dump_last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall     = (state_q != S_IDLE);
	assign cmd.load      = (state_q == S_IDLE) && req_valid;
	assign cmd.compare   = (state_q == S_CMP);
	assign cmd.commit    = (state_q == S_EXEC) && stat.out_free;
	assign cmd.dump_emit = (state_q == S_DUMP) && stat.out_free;

endmodule

// ----- src/sorted_unique_key_table.sv -----
// sorted_unique_key_table: top level, controller plus datapath.
// Insert, delete, update: each transfer runs through capture, compare and execute; the
// result is registered in the execute step, which an output stall holds. Dump: capture, then
// one entry per cycle through the single table read port while the output is not stalled;
// an empty table goes from capture to execute and returns a single ST_EMPTY result.
// Reset clears the entry count and all control state; table contents are not cleared.
`timescale 1ns / 1ps

module sorted_unique_key_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [sukt_pkg::ACT_W-1:0]      action,
	input  logic [sukt_pkg::KEY_W-1:0]      key,
	input  logic [sukt_pkg::WORD_W-1:0]     name_word,
	input  logic [sukt_pkg::WORD_W-1:0]     class_word,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [sukt_pkg::STATUS_W-1:0]   status,
	output logic [sukt_pkg::KEY_W-1:0]      out_key,
	output logic [sukt_pkg::WORD_W-1:0]     out_name,
	output logic [sukt_pkg::WORD_W-1:0]     out_class,
	output logic                            last
);
	import sukt_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	sukt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.action    (action),
		.stat      (stat),
		.cmd       (cmd)
	);

	sukt_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.action     (action),
		.key        (key),
		.name_word  (name_word),
		.class_word (class_word),
		.rsp_stall  (rsp_stall),
		.rsp_valid  (rsp_valid),
		.status     (status),
		.out_key    (out_key),
		.out_name   (out_name),
		.out_class  (out_class),
		.last       (last)
	);

endmodule

// ----- tb/tb_sorted_unique_key_table.sv -----
// Testbench for sorted_unique_key_table: directed and random table commands with
// a class-based scoreboard that predicts every response. Depends on sukt_pkg.
`timescale 1ns / 1ps

module tb_sorted_unique_key_table;
	import sukt_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int POOL_SIZE    = 24;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

	typedef struct {
		status_t             status;
		logic [KEY_W-1:0]    key;
		logic [WORD_W-1:0]   nm;
		logic [WORD_W-1:0]   cls;
		logic                last;
	} table_result_t;

	class key_table_scoreboard;
		logic [KEY_W-1:0]  keys    [CAPACITY];
		logic [WORD_W-1:0] names   [CAPACITY];
		logic [WORD_W-1:0] classes [CAPACITY];
		int                count;
		int                mismatches;
		table_result_t     expected_q [$];

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function void push_expected(status_t st, logic [KEY_W-1:0] k, logic [WORD_W-1:0] nm,
				logic [WORD_W-1:0] cl, logic lst);
			table_result_t r;
			r.status = st;
			r.key = k;
			r.nm = nm;
			r.cls = cl;
			r.last = lst;
			expected_q.push_back(r);
		endfunction

		function void note_request(action_t act, logic [KEY_W-1:0] k, logic [WORD_W-1:0] nm,
				logic [WORD_W-1:0] cl);
			int      pos;
			int      i;
			bit      hit;
			status_t st;
			if (act == ACT_DUMP) begin
				if (count == 0)
					push_expected(ST_EMPTY, k, '0, '0, 1'b1);
				else
					for (i = 0; i < count; i++)
						push_expected(ST_ENTRY, keys[i], names[i], classes[i],
							i == count - 1);
				return;
			end
			pos = 0;
			while (pos < count && keys[pos] < k)
				pos++;
			hit = (pos < count) && (keys[pos] == k);
			case (act)
				ACT_INSERT: begin
					if (hit) begin
						st = ST_DUPLICATE;
					end else if (count >= CAPACITY) begin
						st = ST_FULL;
					end else begin
						st = (pos == 0) ? ST_INS_HEAD :
							((pos == count) ? ST_INS_TAIL : ST_INS_MID);
						for (i = count; i > pos; i--) begin
							keys[i] = keys[i-1];
							names[i] = names[i-1];
							classes[i] = classes[i-1];
						end
						keys[pos] = k;
						names[pos] = nm;
						classes[pos] = cl;
						count++;
					end
				end
				ACT_DELETE: begin
					if (count == 0) begin
						st = ST_EMPTY;
					end else if (!hit) begin
						st = ST_NOT_FOUND;
					end else begin
						st = (pos == 0) ? ST_DEL_HEAD :
							((pos + 1 == count) ? ST_DEL_TAIL : ST_DEL_MID);
						for (i = pos; i + 1 < count; i++) begin
							keys[i] = keys[i+1];
							names[i] = names[i+1];
							classes[i] = classes[i+1];
						end
						count--;
					end
				end
				default: begin
					if (hit) begin
						names[pos] = nm;
						classes[pos] = cl;
						st = ST_UPDATED;
					end else begin
						st = ST_NOT_FOUND;
					end
				end
			endcase
			push_expected(st, k, '0, '0, 1'b1);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [KEY_W-1:0] k,
				logic [WORD_W-1:0] nm, logic [WORD_W-1:0] cl, logic lst);
			table_result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response: status=%0d key=%h name=%h class=%h last=%b",
						st, k, nm, cl, lst);
				return;
			end
			e = expected_q.pop_front();
			if (st !== e.status || k !== e.key || nm !== e.nm || cl !== e.cls ||
					lst !== e.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch expected: status=%0d key=%h name=%h class=%h last=%b",
						e.status, e.key, e.nm, e.cls, e.last);
					$display("         actual:   status=%0d key=%h name=%h class=%h last=%b",
						st, k, nm, cl, lst);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	logic [ACT_W-1:0]    action = '0;
	logic [KEY_W-1:0]    key = '0;
	logic [WORD_W-1:0]   name_word = '0;
	logic [WORD_W-1:0]   class_word = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    out_key;
	logic [WORD_W-1:0]   out_name;
	logic [WORD_W-1:0]   out_class;
	logic                last;

	key_table_scoreboard table_sb;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  cycles = 0;
	logic [KEY_W-1:0]    key_pool [POOL_SIZE];

	sorted_unique_key_table dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.key        (key),
		.name_word  (name_word),
		.class_word (class_word),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.out_key    (out_key),
		.out_name   (out_name),
		.out_class  (out_class),
		.last       (last)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			table_sb.check_result(status, out_key, out_name, out_class, last);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_request(action_t act, logic [KEY_W-1:0] k, logic [WORD_W-1:0] nm,
			logic [WORD_W-1:0] cl);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		action <= act;
		key <= k;
		name_word <= nm;
		class_word <= cl;
		do
			@(posedge clk);
		while (req_stall);
		table_sb.note_request(act, k, nm, cl);
	endtask

	// hold the sender off until every predicted response has come back
	task automatic drain_responses();
		@(negedge clk);
		req_valid <= 1'b0;
		while (table_sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		send_request(ACT_DUMP,   KEY_MAX,  '1, '1);
		send_request(ACT_DELETE, '0,       '0, '0);
		send_request(ACT_UPDATE, 31'd5,    64'h1, 64'h2);
		send_request(ACT_INSERT, KEY_MAX,  '1, '1);
		send_request(ACT_DELETE, KEY_MAX,  '0, '0);
		send_request(ACT_INSERT, 31'd1000, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
		send_request(ACT_INSERT, '0,       '0, '1);
		send_request(ACT_INSERT, KEY_MAX,  '0, '0);
		send_request(ACT_INSERT, 31'd500,  64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		send_request(ACT_INSERT, 31'd500,  '1, '1);
		send_request(ACT_UPDATE, 31'd500,  '1, '0);
		send_request(ACT_UPDATE, 31'd7,    '1, '1);
		send_request(ACT_DUMP,   31'h2AAA_AAAA, '1, '1);
		send_request(ACT_DELETE, 31'd3,    '0, '0);
		send_request(ACT_DELETE, 31'd500,  '0, '0);
		send_request(ACT_DELETE, KEY_MAX,  '0, '0);
		send_request(ACT_DELETE, '0,       '0, '0);
		send_request(ACT_DUMP,   '0,       '0, '0);
	endtask

	// alternate fill-heavy and drain-heavy stretches so the table swings between empty and full
	task automatic run_random(int n);
		int               i;
		int               r;
		int               kr;
		action_t          act;
		logic [KEY_W-1:0] k;
		bit               fill;
		for (i = 0; i < n; i++) begin
			fill = ((i / 50) % 2) == 0;
			r = $urandom_range(99);
			if (fill)
				act = (r < 60) ? ACT_INSERT : (r < 70) ? ACT_DELETE :
					(r < 85) ? ACT_UPDATE : ACT_DUMP;
			else
				act = (r < 15) ? ACT_INSERT : (r < 70) ? ACT_DELETE :
					(r < 85) ? ACT_UPDATE : ACT_DUMP;
			kr = $urandom_range(99);
			if (kr < 80)
				k = key_pool[$urandom_range(POOL_SIZE - 1)];
			else if (kr < 92)
				k = KEY_W'($urandom);
			else
				k = kr[0] ? KEY_MAX : '0;
			send_request(act, k, {$urandom, $urandom}, {$urandom, $urandom});
		end
	endtask

	initial begin
		int i;
		table_sb = new();
		key_pool[0] = '0;
		key_pool[1] = KEY_MAX;
		for (i = 2; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom);
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 34;
		recv_stall_pct = 53;
		run_directed();
		run_random(130);
		drain_responses();

		send_idle_pct = 53;
		recv_stall_pct = 34;
		run_random(130);
		drain_responses();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(140);
		drain_responses();
		repeat (20) @(posedge clk);

		if (table_sb.mismatches == 0 && table_sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
src/sukt_pkg.sv
src/sukt_datapath.sv
src/sukt_ctrl.sv
src/sorted_unique_key_table.sv
tb/tb_sorted_unique_key_table.sv
